// ===== hw/rtl/bspl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bspl_pkg
// Shared widths, codes and helpers for the sector box point locator.
// ----------------------------------------------------------------------------
package bspl_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // (min + max) - 2 * point needs two more bits than a coordinate
  localparam int unsigned OFF_W  = COORD_W + 2;
  localparam int unsigned SQ_W   = 2 * OFF_W;
  localparam int unsigned DIST_W = 54;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Z = CFG_IDX_W'(2);

  localparam logic [KIND_W-1:0] KIND_REAL     = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_VIRTUAL  = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_FALLBACK = KIND_W'(2);

  localparam logic signed [PRIO_W-1:0] PRIO_LOWEST = {1'b1, {(PRIO_W-1){1'b0}}};
  localparam logic [DIST_W-1:0]        DIST_MAX    = {DIST_W{1'b1}};

  typedef logic signed [COORD_W-1:0] coord_t;

  // Offer of one box to a track, and the track's view after the offer
  typedef struct packed {
    logic                      valid;
    logic                      clear;
    logic [ID_W-1:0]           id;
    logic signed [PRIO_W-1:0]  prio;
    logic [DIST_W-1:0]         dist_sq;
  } bspl_offer_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
  } bspl_best_t;

  // Magnitude of the doubled center offset on one axis
  function automatic logic [OFF_W-1:0] axis_mag(coord_t lo, coord_t hi, coord_t p);
    logic signed [OFF_W-1:0] off;
    off = OFF_W'(lo) + OFF_W'(hi) - (OFF_W'(p) <<< 1);
    return off[OFF_W-1] ? OFF_W'(-off) : OFF_W'(off);
  endfunction

endpackage : bspl_pkg
`default_nettype wire

// ===== hw/rtl/bspl_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bspl_in_if / bspl_out_if
// Valid/ready channels carrying sector boxes in and located sectors out.
// ----------------------------------------------------------------------------
interface bspl_in_if;
  logic                              valid;
  logic                              ready;
  logic [bspl_pkg::ID_W-1:0]         sector_id;
  logic signed [bspl_pkg::COORD_W-1:0] min_x;
  logic signed [bspl_pkg::COORD_W-1:0] min_y;
  logic signed [bspl_pkg::COORD_W-1:0] min_z;
  logic signed [bspl_pkg::COORD_W-1:0] max_x;
  logic signed [bspl_pkg::COORD_W-1:0] max_y;
  logic signed [bspl_pkg::COORD_W-1:0] max_z;
  logic signed [bspl_pkg::PRIO_W-1:0]  priority_req;
  logic                              virt_flag;
  logic                              last;

  modport source (
    output valid, sector_id, min_x, min_y, min_z, max_x, max_y, max_z,
           priority_req, virt_flag, last,
    input  ready
  );
  modport sink (
    input  valid, sector_id, min_x, min_y, min_z, max_x, max_y, max_z,
           priority_req, virt_flag, last,
    output ready
  );
endinterface : bspl_in_if

interface bspl_out_if;
  logic                        valid;
  logic                        ready;
  logic [bspl_pkg::ID_W-1:0]   chosen_sector;
  logic [bspl_pkg::KIND_W-1:0] choice_kind;

  modport source (output valid, chosen_sector, choice_kind, input ready);
  modport sink   (input valid, chosen_sector, choice_kind, output ready);
endinterface : bspl_out_if
`default_nettype wire

// ===== hw/rtl/bspl_track.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bspl_track
// Running best box of one track: priority first, then nearer center.
// ----------------------------------------------------------------------------
module bspl_track (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire bspl_pkg::bspl_offer_t offer_i,
  output bspl_pkg::bspl_best_t       best_o
);
  import bspl_pkg::*;

  logic                     found_q, found_d;
  logic [ID_W-1:0]          id_q, id_d;
  logic signed [PRIO_W-1:0] prio_q, prio_d;
  logic [DIST_W-1:0]        dist_q, dist_d;
  logic                     win;

  // Equal priority and equal distance keeps the earlier box
  assign win = offer_i.valid &&
               ((offer_i.prio > prio_q) ||
                (offer_i.prio == prio_q && offer_i.dist_sq < dist_q));

  // View after this offer, used by the end-of-scan answer
  assign best_o.found = win | found_q;
  assign best_o.id    = win ? offer_i.id : id_q;

  always_comb begin
    found_d = best_o.found;
    id_d    = best_o.id;
    prio_d  = win ? offer_i.prio : prio_q;
    dist_d  = win ? offer_i.dist_sq : dist_q;
    if (offer_i.clear) begin
      found_d = 1'b0;
      id_d    = '0;
      prio_d  = PRIO_LOWEST;
      dist_d  = DIST_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      id_q    <= '0;
      prio_q  <= PRIO_LOWEST;
      dist_q  <= DIST_MAX;
    end else begin
      found_q <= found_d;
      id_q    <= id_d;
      prio_q  <= prio_d;
      dist_q  <= dist_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    offer_i.clear |=> !found_q && prio_q == PRIO_LOWEST && dist_q == DIST_MAX)
    else $error("track not emptied after end of scan");
  a_win_sets_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    win && !offer_i.clear |=> found_q && id_q == $past(offer_i.id))
    else $error("winning box not kept");
  a_found_has_dist : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> dist_q != DIST_MAX)
    else $error("found track holds reset distance");
`endif

endmodule : bspl_track
`default_nettype wire

// ===== hw/rtl/box_sector_point_locate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_sector_point_locate
// Finds the sector box that holds the configured point over a stream of boxes.
// ----------------------------------------------------------------------------
// Takes one box request per cycle unless the pipeline holds, and answers once
// per scan, on the box marked last. A box passes through four registers: input
// capture, per-axis squared center offsets (three 26x26 multipliers), the
// summed distance, and the track update that loads the result register, which
// offers the answer of a last box. The whole pipeline holds while a result
// waits unclaimed; otherwise the input is ready every cycle. Write the point
// registers only while no box is in flight.
module box_sector_point_locate (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [bspl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [bspl_pkg::COORD_W-1:0]        cfg_data_i,
  bspl_in_if.sink                                  in_i,
  bspl_out_if.source                               out_o
);
  import bspl_pkg::*;

  logic adv;

  // Point registers
  coord_t pt_x_q, pt_y_q, pt_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_x_q <= '0;
      pt_y_q <= '0;
      pt_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POINT_X: pt_x_q <= cfg_data_i;
        CFG_POINT_Y: pt_y_q <= cfg_data_i;
        CFG_POINT_Z: pt_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: capture request
  logic                     v1_q;
  logic [ID_W-1:0]          id1_q;
  coord_t                   mnx1_q, mny1_q, mnz1_q, mxx1_q, mxy1_q, mxz1_q;
  logic signed [PRIO_W-1:0] prio1_q;
  logic                     virt1_q, last1_q;

  assign adv         = !out_o.valid || out_o.ready;
  assign in_i.ready  = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      id1_q   <= in_i.sector_id;
      mnx1_q  <= in_i.min_x;
      mny1_q  <= in_i.min_y;
      mnz1_q  <= in_i.min_z;
      mxx1_q  <= in_i.max_x;
      mxy1_q  <= in_i.max_y;
      mxz1_q  <= in_i.max_z;
      prio1_q <= in_i.priority_req;
      virt1_q <= in_i.virt_flag;
      last1_q <= in_i.last;
    end
  end

  // Stage 2: containment and squared offsets
  logic                     v2_q;
  logic [ID_W-1:0]          id2_q;
  logic signed [PRIO_W-1:0] prio2_q;
  logic                     virt2_q, last2_q, hit2_q;
  logic [SQ_W-1:0]          sqx2_q, sqy2_q, sqz2_q;
  logic [OFF_W-1:0]         magx, magy, magz;
  logic                     hit1;

  assign hit1 = (mnx1_q <= pt_x_q) && (pt_x_q <= mxx1_q) &&
                (mny1_q <= pt_y_q) && (pt_y_q <= mxy1_q) &&
                (mnz1_q <= pt_z_q) && (pt_z_q <= mxz1_q);
  assign magx = axis_mag(mnx1_q, mxx1_q, pt_x_q);
  assign magy = axis_mag(mny1_q, mxy1_q, pt_y_q);
  assign magz = axis_mag(mnz1_q, mxz1_q, pt_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      id2_q   <= id1_q;
      prio2_q <= prio1_q;
      virt2_q <= virt1_q;
      last2_q <= last1_q;
      hit2_q  <= hit1;
      sqx2_q  <= SQ_W'(magx) * SQ_W'(magx);
      sqy2_q  <= SQ_W'(magy) * SQ_W'(magy);
      sqz2_q  <= SQ_W'(magz) * SQ_W'(magz);
    end
  end

  // Stage 3: distance sum
  logic                     v3_q;
  logic [ID_W-1:0]          id3_q;
  logic signed [PRIO_W-1:0] prio3_q;
  logic                     virt3_q, last3_q, hit3_q;
  logic [DIST_W-1:0]        dist3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      id3_q   <= id2_q;
      prio3_q <= prio2_q;
      virt3_q <= virt2_q;
      last3_q <= last2_q;
      hit3_q  <= hit2_q;
      dist3_q <= DIST_W'(sqx2_q) + DIST_W'(sqy2_q) + DIST_W'(sqz2_q);
    end
  end

  // Stage 4: track update and result
  bspl_offer_t real_offer, virt_offer;
  bspl_best_t  real_best, virt_best;
  logic        step;

  assign step = adv && v3_q;

  always_comb begin
    real_offer.valid   = step && hit3_q && !virt3_q;
    real_offer.clear   = step && last3_q;
    real_offer.id      = id3_q;
    real_offer.prio    = prio3_q;
    real_offer.dist_sq = dist3_q;
    virt_offer         = real_offer;
    virt_offer.valid   = step && hit3_q && virt3_q;
  end

  bspl_track u_real_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .offer_i (real_offer),
    .best_o  (real_best)
  );

  bspl_track u_virt_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .offer_i (virt_offer),
    .best_o  (virt_best)
  );

  logic              out_valid_q;
  logic [ID_W-1:0]   chosen_q, chosen_d;
  logic [KIND_W-1:0] kind_q, kind_d;

  always_comb begin
    if (real_best.found) begin
      chosen_d = real_best.id;
      kind_d   = KIND_REAL;
    end else if (virt_best.found) begin
      chosen_d = virt_best.id;
      kind_d   = KIND_VIRTUAL;
    end else begin
      chosen_d = id3_q;
      kind_d   = KIND_FALLBACK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v3_q && last3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last3_q) begin
      chosen_q <= chosen_d;
      kind_q   <= kind_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.chosen_sector = chosen_q;
  assign out_o.choice_kind   = kind_q;

`ifndef SYNTHESIS
  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v3_q && last3_q))
    else $error("result raised without a last box");
  a_no_result_mid_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !last3_q |=> !out_valid_q)
    else $error("result raised for a box that is not last");
  a_stall_holds_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v1_q, v2_q, v3_q}))
    else $error("pipeline moved while stalled");
  a_fallback_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (kind_q == KIND_REAL || kind_q == KIND_VIRTUAL ||
                     kind_q == KIND_FALLBACK))
    else $error("undefined choice kind");
`endif

endmodule : box_sector_point_locate
`default_nettype wire
